@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvp assertion failed");

// next-cycle implication, checked outside reset
`define CSVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvp assertion failed");

`endif

@@ sv/csvp_pkg.sv @@
`timescale 1ns / 1ps
package csvp_pkg;

  localparam int ACC_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  // character classes seen by the parser
  typedef enum logic [3:0] {
    CC_OTHER, CC_WS, CC_VTFF, CC_NL, CC_CR, CC_NUL, CC_HASH, CC_SLASH,
    CC_PLUS, CC_MINUS, CC_COMMA, CC_ZERO, CC_OCT, CC_DEC, CC_HEX, CC_X
  } char_class_t;

  typedef enum logic [3:0] {
    PH_LINE_START, PH_LINE_SLASH, PH_SKIP_LINE, PH_FIELD_WS, PH_LEAD,
    PH_SIGN, PH_ZERO, PH_ZERO_X, PH_DIGITS, PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC, RADIX_OCT, RADIX_HEX
  } radix_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } char_item_t;

endpackage

@@ sv/csvp_front.sv @@
`timescale 1ns / 1ps
module csvp_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                push,
  output csvp_pkg::char_item_t push_item
);
  import csvp_pkg::*;

  char_class_t cls;
  logic [3:0]  digit;

  always_comb begin
    digit = in_tdata[3:0];
    if ((in_tdata >= CH_LC_A && in_tdata <= CH_LC_F) ||
        (in_tdata >= CH_UC_A && in_tdata <= CH_UC_F)) begin
      digit = {1'b0, in_tdata[2:0]} + 4'd9;
    end
  end

  always_comb begin
    cls = CC_OTHER;
    if (in_tdata == CH_SPACE || in_tdata == CH_TAB) cls = CC_WS;
    else if (in_tdata == CH_VT || in_tdata == CH_FF) cls = CC_VTFF;
    else if (in_tdata == CH_NL) cls = CC_NL;
    else if (in_tdata == CH_CR) cls = CC_CR;
    else if (in_tdata == CH_NUL) cls = CC_NUL;
    else if (in_tdata == CH_HASH) cls = CC_HASH;
    else if (in_tdata == CH_SLASH) cls = CC_SLASH;
    else if (in_tdata == CH_PLUS) cls = CC_PLUS;
    else if (in_tdata == CH_MINUS) cls = CC_MINUS;
    else if (in_tdata == CH_COMMA) cls = CC_COMMA;
    else if (in_tdata == CH_0) cls = CC_ZERO;
    else if (in_tdata >= CH_1 && in_tdata <= CH_7) cls = CC_OCT;
    else if (in_tdata == CH_8 || in_tdata == CH_9) cls = CC_DEC;
    else if ((in_tdata >= CH_LC_A && in_tdata <= CH_LC_F) ||
             (in_tdata >= CH_UC_A && in_tdata <= CH_UC_F)) cls = CC_HEX;
    else if (in_tdata == CH_LC_X || in_tdata == CH_UC_X) cls = CC_X;
  end

  assign in_tready       = !q_full;
  assign push            = in_tvalid && !q_full;
  assign push_item.cls   = cls;
  assign push_item.digit = digit;
  assign push_item.last  = in_tlast;

endmodule

@@ sv/csvp_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csvp_queue #(
  parameter int DEPTH = csvp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  csvp_pkg::char_item_t push_item,
  output logic                 full,
  output logic                 not_empty,
  input  logic                 pop_req,
  output csvp_pkg::char_item_t head_item
);
  import csvp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  char_item_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop       = pop_req && not_empty;
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  `CSVP_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)
  `CSVP_ASSERT_NOW(a_q_no_push_full, clk, rst_n, full, !push)
  `CSVP_ASSERT_NEXT(a_q_shrink, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

@@ sv/csvp_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csvp_back #(
  parameter int ACC_WIDTH = csvp_pkg::ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  csvp_pkg::char_item_t item,
  output logic                 item_take,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic [0:0]           out_tuser
);
  import csvp_pkg::*;

  localparam int MW = ACC_WIDTH + 4;

  phase_t               phase_r, phase_nxt, ph_w;
  radix_t               radix_r, radix_nxt, rad_w;
  logic                 neg_r, neg_nxt, neg_w;
  logic [ACC_WIDTH-1:0] acc_r, acc_nxt, acc_w;
  logic                 ovf_r, ovf_nxt, ovf_w;
  logic                 lcr_r, lcr_nxt, lcr_w;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_num_r, out_num_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic          step, sf, fin, emit_w, emit;
  logic          dig_ok;
  logic [MW-1:0] acc_ext, mul, mac;
  logic          mac_ovf;
  logic [31:0]   low_w;

  assign item_take = item_valid && (!out_valid_r || out_tready);
  assign step      = item_take;

  // one multiply-accumulate step, widened so the overflow shows in the top bits
  always_comb begin
    acc_ext = MW'(acc_r);
    case (radix_r)
      RADIX_HEX: mul = acc_ext << 4;
      RADIX_OCT: mul = acc_ext << 3;
      default:   mul = (acc_ext << 3) + (acc_ext << 1);
    endcase
    mac     = mul + MW'(item.digit);
    mac_ovf = |mac[MW-1:ACC_WIDTH];
  end

  always_comb begin
    case (radix_r)
      RADIX_HEX: dig_ok = (item.cls inside {CC_ZERO, CC_OCT, CC_DEC, CC_HEX});
      RADIX_OCT: dig_ok = (item.cls inside {CC_ZERO, CC_OCT});
      default:   dig_ok = (item.cls inside {CC_ZERO, CC_OCT, CC_DEC});
    endcase
  end

  always_comb begin
    ph_w   = phase_r;
    rad_w  = radix_r;
    neg_w  = neg_r;
    acc_w  = acc_r;
    ovf_w  = ovf_r;
    lcr_w  = lcr_r;
    sf     = 1'b0;
    fin    = 1'b0;
    emit_w = 1'b0;

    unique case (phase_r)
      PH_LINE_START: begin
        if (item.cls == CC_WS) ph_w = PH_LINE_START;
        else if (item.cls inside {CC_CR, CC_NUL}) ph_w = PH_SKIP_LINE;
        else if (item.cls == CC_NL) ph_w = PH_LINE_START;
        else if (item.cls == CC_HASH) ph_w = PH_SKIP_LINE;
        else if (item.cls == CC_SLASH) begin
          rad_w = RADIX_DEC;
          neg_w = 1'b0;
          acc_w = '0;
          ovf_w = 1'b0;
          lcr_w = 1'b0;
          ph_w  = PH_LINE_SLASH;
        end else sf = 1'b1;
      end
      PH_LINE_SLASH: begin
        if (item.cls == CC_SLASH) ph_w = PH_SKIP_LINE;
        else fin = 1'b1;
      end
      PH_SKIP_LINE: begin
        if (item.cls == CC_NL) ph_w = PH_LINE_START;
      end
      PH_FIELD_WS: begin
        if (item.cls == CC_WS) ph_w = PH_FIELD_WS;
        else if (item.cls inside {CC_CR, CC_NUL}) ph_w = PH_SKIP_LINE;
        else if (item.cls == CC_NL) ph_w = PH_LINE_START;
        else sf = 1'b1;
      end
      PH_LEAD: begin
        if (item.cls inside {CC_WS, CC_VTFF}) ph_w = PH_LEAD;
        else if (item.cls == CC_CR) lcr_w = 1'b1;
        else if (item.cls inside {CC_PLUS, CC_MINUS}) begin
          neg_w = (item.cls == CC_MINUS);
          ph_w  = PH_SIGN;
        end else if (item.cls == CC_ZERO) ph_w = PH_ZERO;
        else if (item.cls inside {CC_OCT, CC_DEC}) begin
          acc_w = ACC_WIDTH'(item.digit);
          ph_w  = PH_DIGITS;
        end else fin = 1'b1;
      end
      PH_SIGN: begin
        if (item.cls == CC_ZERO) ph_w = PH_ZERO;
        else if (item.cls inside {CC_OCT, CC_DEC}) begin
          acc_w = ACC_WIDTH'(item.digit);
          ph_w  = PH_DIGITS;
        end else fin = 1'b1;
      end
      PH_ZERO: begin
        if (item.cls inside {CC_ZERO, CC_OCT}) begin
          rad_w = RADIX_OCT;
          acc_w = ACC_WIDTH'(item.digit);
          ph_w  = PH_DIGITS;
        end else if (item.cls == CC_X) ph_w = PH_ZERO_X;
        else fin = 1'b1;
      end
      PH_ZERO_X: begin
        if (item.cls inside {CC_ZERO, CC_OCT, CC_DEC, CC_HEX}) begin
          rad_w = RADIX_HEX;
          acc_w = ACC_WIDTH'(item.digit);
          ph_w  = PH_DIGITS;
        end else fin = 1'b1;
      end
      PH_DIGITS: begin
        if (dig_ok) begin
          if (!ovf_r) begin
            if (mac_ovf) ovf_w = 1'b1;
            else acc_w = mac[ACC_WIDTH-1:0];
          end
        end else fin = 1'b1;
      end
      PH_TAIL: fin = 1'b1;
      default: ph_w = PH_LINE_START;
    endcase

    // first character of a field
    if (sf) begin
      rad_w = RADIX_DEC;
      neg_w = 1'b0;
      acc_w = '0;
      ovf_w = 1'b0;
      lcr_w = 1'b0;
      if (item.cls == CC_VTFF) ph_w = PH_LEAD;
      else if (item.cls inside {CC_PLUS, CC_MINUS}) begin
        neg_w = (item.cls == CC_MINUS);
        ph_w  = PH_SIGN;
      end else if (item.cls == CC_ZERO) ph_w = PH_ZERO;
      else if (item.cls inside {CC_OCT, CC_DEC}) begin
        acc_w = ACC_WIDTH'(item.digit);
        ph_w  = PH_DIGITS;
      end else fin = 1'b1;
    end

    // number part done: decide where the field ends
    if (fin) begin
      emit_w = 1'b1;
      if (item.cls == CC_NL) ph_w = PH_LINE_START;
      else if (lcr_w || item.cls == CC_CR || item.cls == CC_NUL) ph_w = PH_SKIP_LINE;
      else if (item.cls == CC_COMMA) ph_w = PH_FIELD_WS;
      else begin
        ph_w   = PH_TAIL;
        emit_w = 1'b0;
      end
    end
  end

  always_comb begin
    emit = emit_w || (item.last && !(ph_w inside {PH_LINE_START, PH_SKIP_LINE, PH_FIELD_WS}));
    low_w = acc_w[31:0];
    if (neg_w) low_w = 32'd0 - acc_w[31:0];

    phase_nxt     = phase_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    lcr_nxt       = lcr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_num_nxt   = out_num_r;
    out_sat_nxt   = out_sat_r;

    if (step) begin
      phase_nxt = item.last ? PH_LINE_START : ph_w;
      if (emit || item.last) begin
        radix_nxt = RADIX_DEC;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        lcr_nxt   = 1'b0;
      end else begin
        radix_nxt = rad_w;
        neg_nxt   = neg_w;
        acc_nxt   = acc_w;
        ovf_nxt   = ovf_w;
        lcr_nxt   = lcr_w;
      end
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_num_nxt   = ovf_w ? '1 : low_w;
        out_sat_nxt   = ovf_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE_START;
      radix_r     <= RADIX_DEC;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      lcr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      radix_r     <= radix_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      lcr_r       <= lcr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_num_r <= out_num_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_num_r;
  assign out_tuser[0] = out_sat_r;

  `CSVP_ASSERT_NOW(a_sat_all_ones, clk, rst_n, out_valid_r && out_sat_r, out_num_r == 32'hFFFF_FFFF)
  `CSVP_ASSERT_NEXT(a_last_restarts, clk, rst_n, step && item.last, phase_r == PH_LINE_START && acc_r == '0)
  `CSVP_ASSERT_NEXT(a_emit_shows, clk, rst_n, step && emit, out_valid_r)

endmodule

@@ sv/csv_integer_stream_parser.sv @@
`timescale 1ns / 1ps
// path: an accepted byte goes into the byte queue; the back end takes it from the queue head
// and registers the result that drives out_tvalid; throughput: one byte per clock unless a
// stall on out_tready holds the back end, and then the two-entry byte queue fills up behind it
// reset: synchronous, active low; clears the queue, the parse state (line start, empty field)
// and the result valid flag; no clearing pass, the block takes bytes right after reset
module csv_integer_stream_parser #(
  parameter int ACC_WIDTH   = csvp_pkg::ACC_WIDTH_DEF,
  parameter int QUEUE_DEPTH = csvp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request side: one text character per request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // final_byte, last character of the file
  // result side: one parsed field per request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] number
  output logic [0:0]  out_tuser   // [0] saturated
);
  import csvp_pkg::*;

  // front end to queue
  logic       push;
  char_item_t push_item;
  logic       q_full;

  // queue to back end
  logic       q_not_empty;
  logic       take;
  char_item_t head_item;

  // front end: character classification and the input handshake
  csvp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // short queue so the input side keeps flowing while a result waits
  csvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_req   (take),
    .head_item (head_item)
  );

  // back end: line/field state machine, accumulator and result register
  csvp_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (head_item),
    .item_take  (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
